// ===== rtl/core/tss_pkg.sv =====
// ----------------------------------------------------------------------------
// tss_pkg
// Shared sizes, types and literal helpers of the 2-SAT SCC solver.
// ----------------------------------------------------------------------------
`default_nettype none

package tss_pkg;

  localparam int MaxVars    = 256;
  localparam int MaxClauses = 1024;
  localparam int EdgeCap    = 2 * MaxClauses;
  localparam int NodeCount  = 2 * MaxVars + 1;

  localparam int LitW  = 10;
  localparam int NodeW = 10;
  localparam int VarW  = 9;
  localparam int EcntW = 12;                 // holds EdgeCap itself
  localparam int EaddrW = 11;
  localparam int EdgeW = 2 * LitW;           // {to, from}

  localparam logic [NodeW-1:0] ZeroNode = NodeW'(MaxVars);

  localparam logic [1:0] ErrNone     = 2'd0;
  localparam logic [1:0] ErrBadLit   = 2'd1;
  localparam logic [1:0] ErrOverflow = 2'd2;

  typedef struct packed {
    logic done;
    logic sat;
  } solve_status_t;

  // literal is nonzero and its magnitude is within the variable count
  function automatic logic lit_ok(input logic [LitW-1:0] lit, input logic [VarW-1:0] n);
    logic [LitW-1:0] mag;
    mag = lit[LitW-1] ? (~lit + LitW'(1)) : lit;
    return (mag != '0) && (mag <= {1'b0, n});
  endfunction

  function automatic logic [NodeW-1:0] node_of(input logic [LitW-1:0] lit);
    return lit + ZeroNode;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tss_edge_ram.sv =====
// ----------------------------------------------------------------------------
// tss_edge_ram
// Implication edge store: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tss_edge_ram (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [tss_pkg::EaddrW-1:0]  waddr,
  input  wire logic [tss_pkg::EdgeW-1:0]   wdata,
  input  wire logic [tss_pkg::EaddrW-1:0]  raddr,
  output logic      [tss_pkg::EdgeW-1:0]   rdata
);

  logic [tss_pkg::EdgeW-1:0] mem [0:tss_pkg::EdgeCap-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/tss_solver.sv =====
// ----------------------------------------------------------------------------
// tss_solver
// Kosaraju engine: two depth-first passes over the edge store with an
// explicit stack, then a per-variable component compare.
// ----------------------------------------------------------------------------
`default_nettype none

module tss_solver (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        go,
  input  wire logic [tss_pkg::EcntW-1:0]   ecnt,
  input  wire logic [tss_pkg::VarW-1:0]    n,
  output logic      [tss_pkg::EaddrW-1:0]  edge_raddr,
  input  wire logic [tss_pkg::EdgeW-1:0]   edge_rdata,
  output tss_pkg::solve_status_t           stat
);

  localparam int NW = tss_pkg::NodeW;
  localparam int SW = tss_pkg::EcntW + NW;   // stack entry {pos, node}

  typedef enum logic [15:0] {
    S_IDLE   = 16'h0001,
    S_CLR    = 16'h0002,
    S_P1_RD  = 16'h0004,
    S_P1_CHK = 16'h0008,
    S_P2_FRD = 16'h0010,
    S_P2_FW  = 16'h0020,
    S_P2_CHK = 16'h0040,
    S_E_RD   = 16'h0080,
    S_E_CHK  = 16'h0100,
    S_V_CHK  = 16'h0200,
    S_POP_W  = 16'h0400,
    S_WEND   = 16'h0800,
    S_C_RA   = 16'h1000,
    S_C_RB   = 16'h2000,
    S_C_CMP  = 16'h4000,
    S_DONE   = 16'h8000
  } sv_state_t;

  sv_state_t st_r, st_nxt;
  logic                      pass2_r, pass2_nxt;
  logic                      sat_r, sat_nxt;
  logic [NW-1:0]             clr_r, clr_nxt;
  logic [NW-1:0]             outer_r, outer_nxt;
  logic [NW-1:0]             fin_len_r, fin_len_nxt;
  logic [NW-1:0]             idx_r, idx_nxt;
  logic [NW-1:0]             label_r, label_nxt;
  logic [NW-1:0]             top_r, top_nxt;
  logic [NW-1:0]             dst_r, dst_nxt;
  logic [NW-1:0]             sp_r, sp_nxt;
  logic [tss_pkg::EcntW-1:0] e_r, e_nxt;
  logic [tss_pkg::VarW-1:0]  v_r, v_nxt;
  logic [NW-1:0]             comp_a_r, comp_a_nxt;

  // stores sized by node count; vis_mem and comp_mem are node-indexed
  logic          vis_mem  [0:tss_pkg::NodeCount-1];
  logic [NW-1:0] fin_mem  [0:tss_pkg::NodeCount-2];
  logic [NW-1:0] comp_mem [0:tss_pkg::NodeCount-1];
  logic [SW-1:0] stk_mem  [0:tss_pkg::NodeCount-2];

  logic          vis_we, vis_wd, vis_q;
  logic [NW-1:0] vis_wa, vis_ra;
  logic          fin_we;
  logic [NW-2:0] fin_wa, fin_ra;
  logic [NW-1:0] fin_wd, fin_q;
  logic          comp_we;
  logic [NW-1:0] comp_wa, comp_ra, comp_wd, comp_q;
  logic          stk_we;
  logic [NW-2:0] stk_wa, stk_ra;
  logic [SW-1:0] stk_wd, stk_q;

  always_ff @(posedge clk) begin
    if (vis_we) begin
      vis_mem[vis_wa] <= vis_wd;
    end
    vis_q <= vis_mem[vis_ra];
  end

  always_ff @(posedge clk) begin
    if (fin_we) begin
      fin_mem[fin_wa] <= fin_wd;
    end
    fin_q <= fin_mem[fin_ra];
  end

  always_ff @(posedge clk) begin
    if (comp_we) begin
      comp_mem[comp_wa] <= comp_wd;
    end
    comp_q <= comp_mem[comp_ra];
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_wa] <= stk_wd;
    end
    stk_q <= stk_mem[stk_ra];
  end

  logic [tss_pkg::LitW-1:0] lit_from, lit_to;
  logic [NW-1:0]            n_ext, sp_m1, sp_m2, idx_m1;

  always_comb begin
    // the reverse graph is the forward store read with endpoints swapped
    lit_from = pass2_r ? edge_rdata[2*tss_pkg::LitW-1:tss_pkg::LitW]
                       : edge_rdata[tss_pkg::LitW-1:0];
    lit_to   = pass2_r ? edge_rdata[tss_pkg::LitW-1:0]
                       : edge_rdata[2*tss_pkg::LitW-1:tss_pkg::LitW];
    n_ext  = {1'b0, n};
    sp_m1  = sp_r - NW'(1);
    sp_m2  = sp_r - NW'(2);
    idx_m1 = idx_r - NW'(1);
  end

  always_comb begin
    st_nxt      = st_r;
    pass2_nxt   = pass2_r;
    sat_nxt     = sat_r;
    clr_nxt     = clr_r;
    outer_nxt   = outer_r;
    fin_len_nxt = fin_len_r;
    idx_nxt     = idx_r;
    label_nxt   = label_r;
    top_nxt     = top_r;
    dst_nxt     = dst_r;
    sp_nxt      = sp_r;
    e_nxt       = e_r;
    v_nxt       = v_r;
    comp_a_nxt  = comp_a_r;

    vis_we  = 1'b0;
    vis_wa  = clr_r;
    vis_wd  = 1'b0;
    vis_ra  = outer_r;
    fin_we  = 1'b0;
    fin_wa  = fin_len_r[NW-2:0];
    fin_wd  = top_r;
    fin_ra  = idx_m1[NW-2:0];
    comp_we = 1'b0;
    comp_wa = top_r;
    comp_wd = label_r;
    comp_ra = tss_pkg::ZeroNode + {1'b0, v_r};
    stk_we  = 1'b0;
    stk_wa  = sp_m1[NW-2:0];
    stk_wd  = {e_r + tss_pkg::EcntW'(1), top_r};
    stk_ra  = sp_m2[NW-2:0];
    edge_raddr = e_r[tss_pkg::EaddrW-1:0];

    unique case (st_r)
      S_IDLE: begin
        if (go) begin
          pass2_nxt = 1'b0;
          clr_nxt   = '0;
          st_nxt    = S_CLR;
        end
      end
      S_CLR: begin
        vis_we  = 1'b1;
        clr_nxt = clr_r + NW'(1);
        if (clr_r == NW'(tss_pkg::NodeCount - 1)) begin
          if (pass2_r) begin
            idx_nxt   = fin_len_r;
            label_nxt = NW'(1);
            st_nxt    = S_P2_FRD;
          end else begin
            outer_nxt   = tss_pkg::ZeroNode - n_ext;
            fin_len_nxt = '0;
            st_nxt      = S_P1_RD;
          end
        end
      end
      S_P1_RD: begin
        vis_ra = outer_r;
        st_nxt = S_P1_CHK;
      end
      S_P1_CHK: begin
        if (!vis_q) begin
          vis_we = 1'b1;
          vis_wa = outer_r;
          vis_wd = 1'b1;
          top_nxt = outer_r;
          e_nxt   = '0;
          sp_nxt  = NW'(1);
          st_nxt  = S_E_RD;
        end else begin
          st_nxt = S_WEND;
        end
      end
      S_P2_FRD: begin
        if (idx_r == '0) begin
          v_nxt  = tss_pkg::VarW'(1);
          st_nxt = S_C_RA;
        end else begin
          fin_ra  = idx_m1[NW-2:0];
          idx_nxt = idx_m1;
          st_nxt  = S_P2_FW;
        end
      end
      S_P2_FW: begin
        vis_ra  = fin_q;
        dst_nxt = fin_q;
        st_nxt  = S_P2_CHK;
      end
      S_P2_CHK: begin
        if (!vis_q) begin
          vis_we = 1'b1;
          vis_wa = dst_r;
          vis_wd = 1'b1;
          top_nxt = dst_r;
          e_nxt   = '0;
          sp_nxt  = NW'(1);
          st_nxt  = S_E_RD;
        end else begin
          st_nxt = S_P2_FRD;
        end
      end
      S_E_RD: begin
        if (e_r == ecnt) begin
          // every edge of the top node scanned: finish it
          if (pass2_r) begin
            comp_we = 1'b1;
          end else begin
            fin_we      = 1'b1;
            fin_len_nxt = fin_len_r + NW'(1);
          end
          sp_nxt = sp_m1;
          if (sp_r == NW'(1)) begin
            st_nxt = S_WEND;
          end else begin
            stk_ra = sp_m2[NW-2:0];
            st_nxt = S_POP_W;
          end
        end else begin
          edge_raddr = e_r[tss_pkg::EaddrW-1:0];
          st_nxt     = S_E_CHK;
        end
      end
      S_E_CHK: begin
        if (tss_pkg::lit_ok(lit_from, n) && tss_pkg::lit_ok(lit_to, n) &&
            tss_pkg::node_of(lit_from) == top_r) begin
          vis_ra  = tss_pkg::node_of(lit_to);
          dst_nxt = tss_pkg::node_of(lit_to);
          st_nxt  = S_V_CHK;
        end else begin
          e_nxt  = e_r + tss_pkg::EcntW'(1);
          st_nxt = S_E_RD;
        end
      end
      S_V_CHK: begin
        if (vis_q) begin
          e_nxt = e_r + tss_pkg::EcntW'(1);
        end else begin
          vis_we  = 1'b1;
          vis_wa  = dst_r;
          vis_wd  = 1'b1;
          stk_we  = 1'b1;
          top_nxt = dst_r;
          e_nxt   = '0;
          sp_nxt  = sp_r + NW'(1);
        end
        st_nxt = S_E_RD;
      end
      S_POP_W: begin
        top_nxt = stk_q[NW-1:0];
        e_nxt   = stk_q[SW-1:NW];
        st_nxt  = S_E_RD;
      end
      S_WEND: begin
        if (pass2_r) begin
          label_nxt = label_r + NW'(1);
          st_nxt    = S_P2_FRD;
        end else if (outer_r == tss_pkg::ZeroNode + n_ext) begin
          pass2_nxt = 1'b1;
          clr_nxt   = '0;
          st_nxt    = S_CLR;
        end else begin
          // the middle node stands for literal zero and is skipped
          outer_nxt = (outer_r == tss_pkg::ZeroNode - NW'(1)) ? outer_r + NW'(2)
                                                              : outer_r + NW'(1);
          st_nxt    = S_P1_RD;
        end
      end
      S_C_RA: begin
        if (v_r > n) begin
          sat_nxt = 1'b1;
          st_nxt  = S_DONE;
        end else begin
          comp_ra = tss_pkg::ZeroNode + {1'b0, v_r};
          st_nxt  = S_C_RB;
        end
      end
      S_C_RB: begin
        comp_a_nxt = comp_q;
        comp_ra    = tss_pkg::ZeroNode - {1'b0, v_r};
        st_nxt     = S_C_CMP;
      end
      S_C_CMP: begin
        if (comp_q == comp_a_r) begin
          sat_nxt = 1'b0;
          st_nxt  = S_DONE;
        end else begin
          v_nxt  = v_r + tss_pkg::VarW'(1);
          st_nxt = S_C_RA;
        end
      end
      S_DONE: begin
        st_nxt = S_IDLE;
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      pass2_r <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      pass2_r <= pass2_nxt;
    end
    sat_r     <= sat_nxt;
    clr_r     <= clr_nxt;
    outer_r   <= outer_nxt;
    fin_len_r <= fin_len_nxt;
    idx_r     <= idx_nxt;
    label_r   <= label_nxt;
    top_r     <= top_nxt;
    dst_r     <= dst_nxt;
    sp_r      <= sp_nxt;
    e_r       <= e_nxt;
    v_r       <= v_nxt;
    comp_a_r  <= comp_a_nxt;
  end

  assign stat.done = (st_r == S_DONE);
  assign stat.sat  = sat_r;

endmodule

`default_nettype wire

// ===== rtl/core/two_sat_scc_solver_core.sv =====
// ----------------------------------------------------------------------------
// two_sat_scc_solver_core
// 2-SAT decision by strongly connected components over stored clauses.
// ----------------------------------------------------------------------------
// Each stored clause writes both implication edges into a
// single-port-write edge store, the first on acceptance and the second from
// T_LOAD2. A clause that is rejected for a bad literal or overflow stores no
// edge. The clause with tlast set ends the problem and yields one result
// transaction. If an error was latched the result follows at once; otherwise
// the solver runs Kosaraju's method. Each pass scans every stored edge once per
// node, so the run time is dominated by the per-node scan of the edge store.
// No new clause is taken while a solve runs or a result waits.
`default_nettype none

module two_sat_scc_solver_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wen,
  input  wire logic [8:0]  cfg_wdata,     // num_vars
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,      // lit_a[9:0], lit_b[19:10], zero pad
  input  wire logic        in_tlast,      // last_clause
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata      // satisfiable[0], error_code[2:1], pad
);

  localparam int LW = tss_pkg::LitW;

  typedef enum logic [2:0] {
    T_IDLE  = 3'b001,
    T_LOAD2 = 3'b010,
    T_SOLVE = 3'b100
  } top_state_t;

  top_state_t                 st_r, st_nxt;
  logic [tss_pkg::VarW-1:0]   nvars_r;
  logic [tss_pkg::EcntW-1:0]  cnt_r, cnt_nxt;
  logic [1:0]                 err_r, err_nxt;
  logic                       last_r, last_nxt;
  logic [tss_pkg::EdgeW-1:0]  e2_r, e2_nxt;
  logic                       ov_r, ov_nxt;
  logic                       osat_r, osat_nxt;
  logic [1:0]                 oerr_r, oerr_nxt;
  logic [tss_pkg::EcntW-1:0]  ecnt_r, ecnt_nxt;

  logic                       accept, go;
  logic [LW-1:0]              lit_a, lit_b;
  logic                       e_we;
  logic [tss_pkg::EaddrW-1:0] e_wa, e_ra;
  logic [tss_pkg::EdgeW-1:0]  e_wd, e_rd;
  tss_pkg::solve_status_t     stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nvars_r <= tss_pkg::VarW'(1);
    end else if (cfg_wen) begin
      if (cfg_wdata == '0) begin
        nvars_r <= tss_pkg::VarW'(1);
      end else if (cfg_wdata > tss_pkg::VarW'(tss_pkg::MaxVars)) begin
        nvars_r <= tss_pkg::VarW'(tss_pkg::MaxVars);
      end else begin
        nvars_r <= cfg_wdata;
      end
    end
  end

  assign in_tready = (st_r == T_IDLE) && !ov_r;
  assign accept    = in_tvalid && in_tready;
  assign lit_a     = in_tdata[LW-1:0];
  assign lit_b     = in_tdata[2*LW-1:LW];

  always_comb begin
    st_nxt   = st_r;
    cnt_nxt  = cnt_r;
    err_nxt  = err_r;
    last_nxt = last_r;
    e2_nxt   = e2_r;
    ov_nxt   = ov_r;
    osat_nxt = osat_r;
    oerr_nxt = oerr_r;
    ecnt_nxt = ecnt_r;
    go       = 1'b0;
    e_we     = 1'b0;
    e_wa     = cnt_r[tss_pkg::EaddrW-1:0];
    e_wd     = {lit_b, ~lit_a + LW'(1)};

    if (ov_r && out_tready) begin
      ov_nxt = 1'b0;
    end

    unique case (st_r)
      T_IDLE: begin
        if (accept) begin
          if (!tss_pkg::lit_ok(lit_a, nvars_r) || !tss_pkg::lit_ok(lit_b, nvars_r)) begin
            if (err_r == tss_pkg::ErrNone) err_nxt = tss_pkg::ErrBadLit;
          end else if ({1'b0, cnt_r} + 13'd2 > 13'(tss_pkg::EdgeCap)) begin
            if (err_r == tss_pkg::ErrNone) err_nxt = tss_pkg::ErrOverflow;
          end else begin
            e_we     = 1'b1;
            e2_nxt   = {lit_a, ~lit_b + LW'(1)};
            last_nxt = in_tlast;
            st_nxt   = T_LOAD2;
          end
          if (st_nxt == T_IDLE && in_tlast) begin
            // no edge stored, so an error is latched
            ov_nxt   = 1'b1;
            osat_nxt = 1'b0;
            oerr_nxt = err_nxt;
            err_nxt  = tss_pkg::ErrNone;
            cnt_nxt  = '0;
          end
        end
      end
      T_LOAD2: begin
        e_we    = 1'b1;
        e_wa    = cnt_r[tss_pkg::EaddrW-1:0] + tss_pkg::EaddrW'(1);
        e_wd    = e2_r;
        cnt_nxt = cnt_r + tss_pkg::EcntW'(2);
        st_nxt  = T_IDLE;
        if (last_r) begin
          cnt_nxt = '0;
          err_nxt = tss_pkg::ErrNone;
          if (err_r != tss_pkg::ErrNone) begin
            ov_nxt   = 1'b1;
            osat_nxt = 1'b0;
            oerr_nxt = err_r;
          end else begin
            ecnt_nxt = cnt_r + tss_pkg::EcntW'(2);
            go       = 1'b1;
            st_nxt   = T_SOLVE;
          end
        end
      end
      T_SOLVE: begin
        if (stat.done) begin
          ov_nxt   = 1'b1;
          osat_nxt = stat.sat;
          oerr_nxt = tss_pkg::ErrNone;
          st_nxt   = T_IDLE;
        end
      end
      default: begin
        st_nxt = T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= T_IDLE;
      cnt_r <= '0;
      err_r <= tss_pkg::ErrNone;
      ov_r  <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
      err_r <= err_nxt;
      ov_r  <= ov_nxt;
    end
    last_r <= last_nxt;
    e2_r   <= e2_nxt;
    osat_r <= osat_nxt;
    oerr_r <= oerr_nxt;
    ecnt_r <= ecnt_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {5'd0, oerr_r, osat_r};

  tss_edge_ram u_edges (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_wa),
    .wdata (e_wd),
    .raddr (e_ra),
    .rdata (e_rd)
  );

  tss_solver u_solver (
    .clk        (clk),
    .rst_n      (rst_n),
    .go         (go),
    .ecnt       (ecnt_r),
    .n          (nvars_r),
    .edge_raddr (e_ra),
    .edge_rdata (e_rd),
    .stat       (stat)
  );

  a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid)
    else $error("input ready while result pending");

  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2:1] != 2'd3)
    else $error("invalid error code");

  a_err_unsat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:1] != tss_pkg::ErrNone |-> !out_tdata[0])
    else $error("satisfiable reported with error");

  a_done_solve: assert property (@(posedge clk) disable iff (!rst_n)
    stat.done |-> st_r == T_SOLVE)
    else $error("solver finished outside solve");

endmodule

`default_nettype wire
